// ===== hw/rtl/calendar_clock_with_alarms_assert.svh =====
// assertion macros for the calendar clock checker
// expects clk and arst_n in the scope where a macro is used
`ifndef CALENDAR_CLOCK_WITH_ALARMS_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_ALARMS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CALCLK_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CALCLK_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/calclk_pkg.sv =====
// shared types, constants and helpers for the calendar clock
// no dependencies
`timescale 1ns / 1ps

package calclk_pkg;

	// field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned TUNE_W  = 2;
	localparam int unsigned TPS_W   = 16;
	localparam int unsigned ALARM_W = 17;
	localparam int unsigned NUM_ALARMS = 3;

	// configuration port
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] REG_ALARM_ZERO_TIME  = 2'd1;
	localparam logic [1:0] REG_ALARM_ONE_TIME   = 2'd2;
	localparam logic [1:0] REG_ALARM_TWO_TIME   = 2'd3;

	// input modes
	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PAUSE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ARM     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SILENCE = 3'd4;

	// reset values
	localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd2881;
	localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2019;
	localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd5;
	localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;

	// rollover limits
	localparam logic [SEC_W:0]    SEC_LIMIT   = 7'd60;
	localparam logic [MIN_W:0]    MIN_LIMIT   = 7'd60;
	localparam logic [HOUR_W:0]   HOUR_LIMIT  = 6'd24;
	localparam logic [MONTH_W:0]  MONTH_LIMIT = 5'd13;
	localparam logic [YEAR_W-1:0] YEAR_LAST   = 14'd9999;

	// packed alarm time: hour, minute, second
	localparam int unsigned ALM_SEC_LSB  = 0;
	localparam int unsigned ALM_MIN_LSB  = 6;
	localparam int unsigned ALM_HOUR_LSB = 12;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [YEAR_W-1:0]  load_year;
		logic [MONTH_W-1:0] load_month;
		logic [DAY_W-1:0]   load_day;
		logic [HOUR_W-1:0]  load_hour;
		logic [MIN_W-1:0]   load_minute;
		logic [SEC_W-1:0]   load_second;
	} item_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic               ringing;
		logic [TUNE_W-1:0]  alarm_tune;
	} result_t;

	// days in a month, no leap years; months out of range count as 31
	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		if (m == 4'd2) begin
			len = 5'd28;
		end else if (m >= 4'd1 && m <= 4'd7) begin
			len = m[0] ? 5'd31 : 5'd30;
		end else if (m >= 4'd8 && m <= 4'd12) begin
			len = m[0] ? 5'd30 : 5'd31;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

// ===== hw/rtl/calclk_if.sv =====
// valid/ready channel interfaces for the calendar clock items and results
// depends on calclk_pkg
`timescale 1ns / 1ps

interface calclk_item_if;
	logic                valid;
	logic                ready;
	calclk_pkg::item_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface calclk_result_if;
	logic                valid;
	logic                ready;
	calclk_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/calendar_clock_with_alarms.sv =====
// Calendar clock with three alarms: top level
// Takes each item and updates the time, alarm and ringer
// state; the result is shown the cycle after the transfer in an output
// register. A new item is taken in every cycle as long as the output
// register is empty or its result is taken in the same cycle, so the block
// runs at one item per cycle, set by the single carry chain from second to
// year and the three alarm compares in front of the state registers.
// Registers over APB (byte address, 32-bit data): 0x0 ticks_per_second,
// 0x4/0x8/0xC alarm 0/1/2 time packed as hour*4096 + minute*64 + second.
// pready is always high; writes belong to idle periods only.
// Depends on calclk_pkg and calclk_if.
`timescale 1ns / 1ps

module calendar_clock_with_alarms (
	input  logic                             clk,
	input  logic                             arst_n,
	calclk_item_if.sink                      item,
	calclk_result_if.source                  result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [calclk_pkg::PADDR_W-1:0]   paddr,
	input  logic [calclk_pkg::PDATA_W-1:0]   pwdata,
	output logic [calclk_pkg::PDATA_W-1:0]   prdata,
	output logic                             pready
);

	// configuration registers
	logic [calclk_pkg::TPS_W-1:0]   tps_q;
	logic [calclk_pkg::ALARM_W-1:0] alarm_q [calclk_pkg::NUM_ALARMS];

	// clock state
	logic [calclk_pkg::TPS_W-1:0]      prescale_q, prescale_n;
	logic                              paused_q, paused_n;
	logic [calclk_pkg::YEAR_W-1:0]     year_q, year_n;
	logic [calclk_pkg::MONTH_W-1:0]    month_q, month_n;
	logic [calclk_pkg::DAY_W-1:0]      day_q, day_n;
	logic [calclk_pkg::HOUR_W-1:0]     hour_q, hour_n;
	logic [calclk_pkg::MIN_W-1:0]      minute_q, minute_n;
	logic [calclk_pkg::SEC_W-1:0]      second_q, second_n;
	logic [calclk_pkg::NUM_ALARMS-1:0] armed_q, armed_n, armed_mode;
	logic                              ring_q, ring_n;
	logic [calclk_pkg::TUNE_W-1:0]     source_q, source_n;

	// output register
	logic                res_valid_q;
	calclk_pkg::result_t res_q;

	// increments, one bit wider for the compares
	logic [calclk_pkg::TPS_W:0]   prescale_inc;
	logic [calclk_pkg::SEC_W:0]   second_inc;
	logic [calclk_pkg::MIN_W:0]   minute_inc;
	logic [calclk_pkg::HOUR_W:0]  hour_inc;
	logic [calclk_pkg::DAY_W:0]   day_inc;
	logic [calclk_pkg::MONTH_W:0] month_inc;
	logic [calclk_pkg::NUM_ALARMS-1:0] match;

	logic in_ready;
	logic in_xfer;
	logic cfg_wr;
	logic [1:0] cfg_idx;

	// handshake: take an item when the output register is free or drains
	assign in_ready   = !res_valid_q || result.ready;
	assign item.ready = in_ready;
	assign in_xfer    = item.valid && in_ready;

	assign prescale_inc = {1'b0, prescale_q} + 17'd1;
	assign second_inc   = {1'b0, second_q} + 7'd1;
	assign minute_inc   = {1'b0, minute_q} + 7'd1;
	assign hour_inc     = {1'b0, hour_q} + 6'd1;
	assign day_inc      = {1'b0, day_q} + 6'd1;
	assign month_inc    = {1'b0, month_q} + 5'd1;

	// mode effect and the carry chain
	always_comb begin
		prescale_n = prescale_q;
		paused_n   = paused_q;
		year_n     = year_q;
		month_n    = month_q;
		day_n      = day_q;
		hour_n     = hour_q;
		minute_n   = minute_q;
		second_n   = second_q;
		armed_mode = armed_q;
		ring_n     = ring_q;
		source_n   = source_q;
		case (item.data.mode)
			calclk_pkg::MODE_TICK: begin
				if (!paused_q) begin
					if (prescale_inc >= {1'b0, tps_q}) begin
						prescale_n = '0;
						if (second_inc < calclk_pkg::SEC_LIMIT) begin
							second_n = second_inc[calclk_pkg::SEC_W-1:0];
						end else begin
							second_n = '0;
							if (minute_inc < calclk_pkg::MIN_LIMIT) begin
								minute_n = minute_inc[calclk_pkg::MIN_W-1:0];
							end else begin
								minute_n = '0;
								if (hour_inc < calclk_pkg::HOUR_LIMIT) begin
									hour_n = hour_inc[calclk_pkg::HOUR_W-1:0];
								end else begin
									hour_n = '0;
									if (day_inc <= {1'b0, calclk_pkg::month_length(month_q)}) begin
										day_n = day_inc[calclk_pkg::DAY_W-1:0];
									end else begin
										day_n = calclk_pkg::DAY_RESET;
										if (month_inc < calclk_pkg::MONTH_LIMIT) begin
											month_n = month_inc[calclk_pkg::MONTH_W-1:0];
										end else begin
											month_n = 4'd1;
											if (year_q >= calclk_pkg::YEAR_LAST) begin
												year_n = '0;
											end else begin
												year_n = year_q + 14'd1;
											end
										end
									end
								end
							end
						end
					end else begin
						prescale_n = prescale_inc[calclk_pkg::TPS_W-1:0];
					end
				end
			end
			calclk_pkg::MODE_PAUSE: begin
				paused_n = 1'b1;
			end
			calclk_pkg::MODE_LOAD: begin
				year_n   = item.data.load_year;
				month_n  = item.data.load_month;
				day_n    = item.data.load_day;
				hour_n   = item.data.load_hour;
				minute_n = item.data.load_minute;
				second_n = item.data.load_second;
				paused_n = 1'b0;
			end
			calclk_pkg::MODE_ARM: begin
				armed_mode = '1;
			end
			calclk_pkg::MODE_SILENCE: begin
				ring_n   = 1'b0;
				source_n = '0;
			end
			default: begin
			end
		endcase

		// alarm compare against the updated time
		for (int i = 0; i < calclk_pkg::NUM_ALARMS; i++) begin
			match[i] = armed_mode[i]
				&& alarm_q[i][calclk_pkg::ALM_HOUR_LSB +: calclk_pkg::HOUR_W] == hour_n
				&& alarm_q[i][calclk_pkg::ALM_MIN_LSB +: calclk_pkg::MIN_W] == minute_n
				&& alarm_q[i][calclk_pkg::ALM_SEC_LSB +: calclk_pkg::SEC_W] == second_n;
		end

		// lowest matching alarm rings and is disarmed
		armed_n = armed_mode;
		for (int i = calclk_pkg::NUM_ALARMS - 1; i >= 0; i--) begin
			if (match[i]) begin
				ring_n   = 1'b1;
				source_n = calclk_pkg::TUNE_W'(i + 1);
				armed_n  = armed_mode & ~(calclk_pkg::NUM_ALARMS'(1) << i);
			end
		end
	end

	// state registers, updated on each item transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			paused_q   <= 1'b0;
			year_q     <= calclk_pkg::YEAR_RESET;
			month_q    <= calclk_pkg::MONTH_RESET;
			day_q      <= calclk_pkg::DAY_RESET;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			armed_q    <= '0;
			ring_q     <= 1'b0;
			source_q   <= '0;
		end else if (in_xfer) begin
			prescale_q <= prescale_n;
			paused_q   <= paused_n;
			year_q     <= year_n;
			month_q    <= month_n;
			day_q      <= day_n;
			hour_q     <= hour_n;
			minute_q   <= minute_n;
			second_q   <= second_n;
			armed_q    <= armed_n;
			ring_q     <= ring_n;
			source_q   <= source_n;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q.year       <= year_n;
			res_q.month      <= month_n;
			res_q.day        <= day_n;
			res_q.hour       <= hour_n;
			res_q.minute     <= minute_n;
			res_q.second     <= second_n;
			res_q.ringing    <= ring_n;
			res_q.alarm_tune <= ring_n ? source_n : '0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// configuration writes
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= calclk_pkg::TPS_RESET;
			for (int i = 0; i < calclk_pkg::NUM_ALARMS; i++) begin
				alarm_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				calclk_pkg::REG_TICKS_PER_SECOND: tps_q      <= pwdata[calclk_pkg::TPS_W-1:0];
				calclk_pkg::REG_ALARM_ZERO_TIME:  alarm_q[0] <= pwdata[calclk_pkg::ALARM_W-1:0];
				calclk_pkg::REG_ALARM_ONE_TIME:   alarm_q[1] <= pwdata[calclk_pkg::ALARM_W-1:0];
				calclk_pkg::REG_ALARM_TWO_TIME:   alarm_q[2] <= pwdata[calclk_pkg::ALARM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (cfg_idx)
			calclk_pkg::REG_TICKS_PER_SECOND: prdata = calclk_pkg::PDATA_W'(tps_q);
			calclk_pkg::REG_ALARM_ZERO_TIME:  prdata = calclk_pkg::PDATA_W'(alarm_q[0]);
			calclk_pkg::REG_ALARM_ONE_TIME:   prdata = calclk_pkg::PDATA_W'(alarm_q[1]);
			calclk_pkg::REG_ALARM_TWO_TIME:   prdata = calclk_pkg::PDATA_W'(alarm_q[2]);
			default:                          prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/calclk_checker.sv =====
// port-level checks for the calendar clock, bound to the top level
// depends on calclk_pkg and calendar_clock_with_alarms_assert.svh
`timescale 1ns / 1ps
`include "calendar_clock_with_alarms_assert.svh"

module calclk_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input calclk_pkg::result_t out_data
);

	// a transfer in always shows a result the next cycle
	`CALCLK_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after transfer")

	// empty output register never blocks the input
	`CALCLK_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input blocked while output empty")

	// tune is nonzero exactly while ringing
	`CALCLK_ASSERT_NOW(a_tune_ring, out_valid,
		out_data.ringing == (out_data.alarm_tune != 2'd0), "tune and ringing disagree")

	// a stalled result holds
	`CALCLK_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
		out_valid && $stable(out_data), "stalled result changed")

endmodule

bind calendar_clock_with_alarms calclk_checker u_calclk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
